[sv/mrva_pkg.sv]
// Shared types and constants for the MIDI round-robin voice allocator.
// No dependencies; compile first.
package mrva_pkg;

   localparam int VOICES_DEF  = 16;
   localparam int MAX_RESULTS = 16;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
   localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
   localparam logic [3:0] MSG_CTRL     = 4'hB;
   localparam logic [3:0] MSG_PROGRAM  = 4'hC;
   localparam logic [3:0] CHAN_ZERO    = 4'h0;
   localparam logic [6:0] CTRL_BANK    = 7'd0;

   typedef struct packed {
      logic [7:0] status_byte;
      logic [6:0] first_data;
      logic [6:0] second_data;
      logic       has_data;
   } req_type;

   typedef struct packed {
      logic [3:0]  voice_index;
      logic        note_on;
      logic        use_patch;
      logic [6:0]  wave_program;
      logic [13:0] patch_number;
      logic [6:0]  note_number;
      logic [6:0]  velocity;
      logic        last_event;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } state_type;

endpackage

[sv/mrva_chan_if.sv]
// Valid/ready channel carrying one payload item per transfer.
// Payload type is a parameter; used with the types in mrva_pkg.
interface mrva_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[sv/mrva_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mrva_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/midi_round_robin_voice_allocator.sv]
// MIDI round-robin voice allocator: top level, sequencer and note-table scan.
// Depends on mrva_pkg, mrva_chan_if and mrva_ram.
//
//   channel  dir  payload   transfer when
//   req_ch   in   req_type  req_ch.valid && req_ch.ready
//   rsp_ch   out  rsp_type  rsp_ch.valid && rsp_ch.ready
//
// Note-off: accept, SCAN of the VOICES entries (one table read per cycle via the
// single RAM read port unless a match stalls on the output), then FLUSH, held while
// the output stalls. Note-on on channel 0: accept, then FLUSH. Other messages: accept only.
// Synchronous reset clears the pointer, program, bank and per-voice valid bits.
// The result register lets a new item be taken while the last result waits.
module midi_round_robin_voice_allocator #(
   parameter int VOICES = mrva_pkg::VOICES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   mrva_chan_if.sink   req_ch,
   mrva_chan_if.source rsp_ch
);

   localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam logic [VW-1:0] LAST_VOICE = VW'(VOICES - 1);

   mrva_pkg::state_type state_ff, state_in;

   logic [VW-1:0]  next_voice_ff;
   logic [6:0]     program_ff;
   logic [6:0]     bank_ff;
   logic [VOICES-1:0] valid_ff;

   logic [VW-1:0]  addr_ff;
   logic [6:0]     key_ff;
   logic [6:0]     vel_ff;
   logic [mrva_pkg::CNT_W-1:0] found_ff;

   logic              pend_vld_ff;
   mrva_pkg::rsp_type pend_ff;
   logic              rsp_vld_ff;
   mrva_pkg::rsp_type rsp_data_ff;

   logic [VW-1:0] rd_addr;
   logic [6:0]    rd_data;
   logic [6:0]    stored_note;

   logic req_xfer, out_free;
   logic is_on, is_off, is_pc, is_bank, chan0;
   logic match, take, scan_stall, scan_last;
   logic load_rsp, load_last, ready_out;

   logic [VW+3:0] scan_voice_ext;
   logic [VW+3:0] on_voice_ext;
   mrva_pkg::rsp_type scan_event;
   mrva_pkg::rsp_type on_event;
   mrva_pkg::rsp_type load_event;

   assign req_xfer = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_vld_ff || rsp_ch.ready;

   assign chan0   = req_ch.payload.status_byte[3:0] == mrva_pkg::CHAN_ZERO;
   assign is_on   = req_xfer && req_ch.payload.has_data
                    && req_ch.payload.status_byte[7:4] == mrva_pkg::MSG_NOTE_ON;
   assign is_off  = req_xfer && req_ch.payload.has_data
                    && req_ch.payload.status_byte[7:4] == mrva_pkg::MSG_NOTE_OFF;
   assign is_pc   = req_xfer && req_ch.payload.has_data
                    && req_ch.payload.status_byte[7:4] == mrva_pkg::MSG_PROGRAM;
   assign is_bank = req_xfer && req_ch.payload.has_data
                    && req_ch.payload.status_byte[7:4] == mrva_pkg::MSG_CTRL
                    && req_ch.payload.first_data == mrva_pkg::CTRL_BANK;

   mrva_ram #(.WIDTH(7), .DEPTH(VOICES)) u_notes (
      .clock   (clock),
      .wr_en   (is_on),
      .wr_addr (next_voice_ff),
      .wr_data (req_ch.payload.first_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign stored_note = valid_ff[addr_ff] ? rd_data : 7'd0;
   assign match       = stored_note == key_ff;
   assign take        = match && (found_ff != mrva_pkg::CNT_W'(mrva_pkg::MAX_RESULTS));
   assign scan_stall  = take && pend_vld_ff && !out_free;
   assign scan_last   = addr_ff == LAST_VOICE;

   assign scan_voice_ext = {4'd0, addr_ff};
   assign on_voice_ext   = {4'd0, next_voice_ff};

   always_comb begin
      scan_event              = '0;
      scan_event.voice_index  = scan_voice_ext[3:0];
      scan_event.velocity     = vel_ff;

      on_event                = '0;
      on_event.voice_index    = on_voice_ext[3:0];
      on_event.note_on        = 1'b1;
      on_event.note_number    = req_ch.payload.first_data;
      on_event.velocity       = req_ch.payload.second_data;
      if (bank_ff != 7'd0) begin
         on_event.use_patch    = 1'b1;
         on_event.patch_number = {bank_ff - 7'd1, program_ff};
      end else begin
         on_event.wave_program = program_ff;
      end

      load_event            = pend_ff;
      load_event.last_event = load_last;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mrva_pkg::ST_IDLE: begin
            if (is_off) begin
               state_in = mrva_pkg::ST_SCAN;
            end else if (is_on && chan0) begin
               state_in = mrva_pkg::ST_FLUSH;
            end
         end
         mrva_pkg::ST_SCAN: begin
            if (!scan_stall && scan_last) begin
               state_in = mrva_pkg::ST_FLUSH;
            end
         end
         mrva_pkg::ST_FLUSH: begin
            if (!pend_vld_ff || out_free) begin
               state_in = mrva_pkg::ST_IDLE;
            end
         end
         default: state_in = mrva_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ready_out = 1'b0;
      rd_addr   = addr_ff;
      load_rsp  = 1'b0;
      load_last = 1'b0;
      unique case (state_ff)
         mrva_pkg::ST_IDLE: begin
            ready_out = 1'b1;
            rd_addr   = '0;
         end
         mrva_pkg::ST_SCAN: begin
            if (!scan_stall && !scan_last) begin
               rd_addr = addr_ff + VW'(1);
            end
            load_rsp = take && pend_vld_ff && out_free;
         end
         mrva_pkg::ST_FLUSH: begin
            load_rsp  = pend_vld_ff && out_free;
            load_last = 1'b1;
         end
         default: ;
      endcase
   end

   assign req_ch.ready   = ready_out;
   assign rsp_ch.valid   = rsp_vld_ff;
   assign rsp_ch.payload = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mrva_pkg::ST_IDLE;
         next_voice_ff <= '0;
         program_ff    <= '0;
         bank_ff       <= '0;
         valid_ff      <= '0;
         pend_vld_ff   <= 1'b0;
         rsp_vld_ff    <= 1'b0;
         found_ff      <= '0;
      end else begin
         state_ff <= state_in;

         if (is_on) begin
            valid_ff[next_voice_ff] <= 1'b1;
            next_voice_ff <= (next_voice_ff == LAST_VOICE) ? '0 : next_voice_ff + VW'(1);
         end
         if (is_pc) begin
            program_ff <= req_ch.payload.first_data;
         end
         if (is_bank) begin
            bank_ff <= req_ch.payload.second_data;
         end

         if (is_off) begin
            found_ff <= '0;
         end else if (state_ff == mrva_pkg::ST_SCAN && take && !scan_stall) begin
            found_ff <= found_ff + mrva_pkg::CNT_W'(1);
         end

         if (is_on && chan0) begin
            pend_vld_ff <= 1'b1;
         end else if (state_ff == mrva_pkg::ST_SCAN && take && !scan_stall) begin
            pend_vld_ff <= 1'b1;
         end else if (state_ff == mrva_pkg::ST_FLUSH && load_rsp) begin
            pend_vld_ff <= 1'b0;
         end

         if (load_rsp) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         addr_ff <= '0;
         key_ff  <= req_ch.payload.first_data;
         vel_ff  <= req_ch.payload.second_data;
      end else if (state_ff == mrva_pkg::ST_SCAN && !scan_stall && !scan_last) begin
         addr_ff <= addr_ff + VW'(1);
      end

      if (is_on && chan0) begin
         pend_ff <= on_event;
      end else if (state_ff == mrva_pkg::ST_SCAN && take && !scan_stall) begin
         pend_ff <= scan_event;
      end

      if (load_rsp) begin
         rsp_data_ff <= load_event;
      end
   end

`ifndef ASSERT_OFF
   a_voice_range: assert property (@(posedge clock) disable iff (reset)
      next_voice_ff <= LAST_VOICE)
      else $error("voice pointer out of range");

   a_found_cap: assert property (@(posedge clock) disable iff (reset)
      found_ff <= mrva_pkg::CNT_W'(mrva_pkg::MAX_RESULTS))
      else $error("match count above limit");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> out_free)
      else $error("result register overwritten");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == mrva_pkg::ST_IDLE |-> !pend_vld_ff)
      else $error("pending event left behind");

   a_scan_closes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mrva_pkg::ST_SCAN && scan_last && !scan_stall)
      |=> state_ff == mrva_pkg::ST_FLUSH)
      else $error("scan did not close");
`endif

endmodule

[bench/midi_round_robin_voice_allocator_tb.sv]
// Self-checking bench for midi_round_robin_voice_allocator: directed and random MIDI messages,
// checked event by event against a behavioral voice-table model in a scoreboard class.
// Depends on mrva_pkg, mrva_chan_if and the allocator RTL.
module midi_round_robin_voice_allocator_tb;

   localparam int VOICES = mrva_pkg::VOICES_DEF;
   localparam int RANDOM_MSGS = 130;

   localparam logic [3:0] MSG_AFTERTOUCH = 4'hA;
   localparam logic [3:0] MSG_PITCH_BEND = 4'hE;
   localparam logic [3:0] MSG_SYSTEM     = 4'hF;
   localparam logic [3:0] MSG_DATA_ONLY  = 4'h7;
   localparam logic [6:0] CTRL_VOLUME    = 7'd7;

   class voice_scoreboard;
      mrva_pkg::rsp_type event_q[$];
      logic [6:0] note_table[VOICES];
      int         next_voice;
      logic [6:0] program_num;
      logic [6:0] bank_num;
      int         errors;

      function new();
         foreach (note_table[v]) note_table[v] = '0;
         next_voice  = 0;
         program_num = '0;
         bank_num    = '0;
         errors      = 0;
      endfunction

      function void note_msg(mrva_pkg::req_type m);
         mrva_pkg::rsp_type ev;
         int hits;
         hits = 0;
         if (!m.has_data) return;
         case (m.status_byte[7:4])
            mrva_pkg::MSG_NOTE_ON: begin
               note_table[next_voice] = m.first_data;
               if (m.status_byte[3:0] == mrva_pkg::CHAN_ZERO) begin
                  ev = '0;
                  ev.voice_index = 4'(next_voice);
                  ev.note_on     = 1'b1;
                  if (bank_num != 0) begin
                     ev.use_patch    = 1'b1;
                     ev.patch_number = 14'((int'(bank_num) - 1) * 128 + int'(program_num));
                  end else begin
                     ev.wave_program = program_num;
                  end
                  ev.note_number = m.first_data;
                  ev.velocity    = m.second_data;
                  ev.last_event  = 1'b1;
                  event_q.push_back(ev);
               end
               next_voice = (next_voice + 1) % VOICES;
            end
            mrva_pkg::MSG_NOTE_OFF: begin
               for (int v = 0; v < VOICES && hits < mrva_pkg::MAX_RESULTS; v++) begin
                  if (note_table[v] == m.first_data) begin
                     ev = '0;
                     ev.voice_index = 4'(v);
                     ev.velocity    = m.second_data;
                     ev.last_event  = 1'b0;
                     event_q.push_back(ev);
                     hits++;
                  end
               end
               if (hits > 0) event_q[event_q.size() - 1].last_event = 1'b1;
            end
            mrva_pkg::MSG_PROGRAM: program_num = m.first_data;
            mrva_pkg::MSG_CTRL: begin
               if (m.first_data == mrva_pkg::CTRL_BANK) bank_num = m.second_data;
            end
            default: ;
         endcase
      endfunction

      function void cmp_field(string name, int want, int got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_event(mrva_pkg::rsp_type got);
         mrva_pkg::rsp_type want;
         if (event_q.size() == 0) begin
            $error("unexpected event: voice %0d note_on %0d", got.voice_index, got.note_on);
            errors++;
            return;
         end
         want = event_q.pop_front();
         cmp_field("voice_index", want.voice_index, got.voice_index);
         cmp_field("note_on", want.note_on, got.note_on);
         cmp_field("use_patch", want.use_patch, got.use_patch);
         cmp_field("wave_program", want.wave_program, got.wave_program);
         cmp_field("patch_number", want.patch_number, got.patch_number);
         cmp_field("note_number", want.note_number, got.note_number);
         cmp_field("velocity", want.velocity, got.velocity);
         cmp_field("last_event", want.last_event, got.last_event);
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   gaps_on;

   mrva_chan_if #(.payload_type(mrva_pkg::req_type)) req_ch ();
   mrva_chan_if #(.payload_type(mrva_pkg::rsp_type)) rsp_ch ();

   voice_scoreboard board = new();

   midi_round_robin_voice_allocator #(.VOICES(VOICES)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("midi_round_robin_voice_allocator_tb: FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= !(gaps_on && $urandom_range(0, 99) < 9);
      end
   end

   // ready and valid are settled by the falling edge; the transfer happens at the next rise
   always @(negedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) board.check_event(rsp_ch.payload);
   end

   task automatic send_msg(logic [7:0] status, logic [6:0] d1, logic [6:0] d2, logic has);
      mrva_pkg::req_type m;
      bit taken;
      m.status_byte = status;
      m.first_data  = d1;
      m.second_data = d2;
      m.has_data    = has;
      while (gaps_on && $urandom_range(0, 99) < 9) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= m;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = req_ch.ready;
         @(posedge clock);
      end
      board.note_msg(m);
   endtask

   function automatic logic [6:0] pick_note();
      if ($urandom_range(0, 3) == 0) return 7'($urandom_range(0, 127));
      return 7'($urandom_range(58, 63));
   endfunction

   initial begin
      int sent;
      int kind;
      int drain;
      logic [3:0] chan;

      reset          = 1'b1;
      gaps_on        = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready   = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed
      send_msg({mrva_pkg::MSG_NOTE_ON, mrva_pkg::CHAN_ZERO}, 7'd127, 7'd127, 1'b0);
      // all voices still note 0
      send_msg({mrva_pkg::MSG_NOTE_OFF, mrva_pkg::CHAN_ZERO}, 7'd0, 7'd127, 1'b1);
      send_msg({mrva_pkg::MSG_NOTE_ON, mrva_pkg::CHAN_ZERO}, 7'd0, 7'd0, 1'b1);
      send_msg({mrva_pkg::MSG_PROGRAM, 4'hF}, 7'd127, 7'd0, 1'b1);
      send_msg({mrva_pkg::MSG_NOTE_ON, mrva_pkg::CHAN_ZERO}, 7'd127, 7'd127, 1'b1);
      send_msg({mrva_pkg::MSG_CTRL, 4'h5}, CTRL_VOLUME, 7'd99, 1'b1);
      send_msg({mrva_pkg::MSG_CTRL, mrva_pkg::CHAN_ZERO}, mrva_pkg::CTRL_BANK, 7'd127, 1'b1);
      // top patch number
      send_msg({mrva_pkg::MSG_NOTE_ON, mrva_pkg::CHAN_ZERO}, 7'd60, 7'd64, 1'b1);
      send_msg({mrva_pkg::MSG_CTRL, 4'hA}, mrva_pkg::CTRL_BANK, 7'd1, 1'b1);
      send_msg({mrva_pkg::MSG_PROGRAM, mrva_pkg::CHAN_ZERO}, 7'd0, 7'd127, 1'b1);
      // patch 0
      send_msg({mrva_pkg::MSG_NOTE_ON, mrva_pkg::CHAN_ZERO}, 7'd60, 7'd1, 1'b1);
      // silent, still takes a voice
      send_msg({mrva_pkg::MSG_NOTE_ON, 4'hF}, 7'd60, 7'd100, 1'b1);
      send_msg({mrva_pkg::MSG_NOTE_OFF, 4'h9}, 7'd60, 7'd64, 1'b1);
      // no match
      send_msg({mrva_pkg::MSG_NOTE_OFF, mrva_pkg::CHAN_ZERO}, 7'd100, 7'd5, 1'b1);
      send_msg({MSG_AFTERTOUCH, mrva_pkg::CHAN_ZERO}, 7'd60, 7'd127, 1'b1);
      send_msg({MSG_PITCH_BEND, 4'h5}, 7'd127, 7'd127, 1'b1);
      send_msg({MSG_SYSTEM, 4'hF}, 7'd127, 7'd127, 1'b1);
      send_msg({MSG_DATA_ONLY, 4'hF}, 7'd85, 7'd42, 1'b1);
      send_msg(8'h00, 7'd0, 7'd0, 1'b1);
      send_msg({mrva_pkg::MSG_CTRL, mrva_pkg::CHAN_ZERO}, mrva_pkg::CTRL_BANK, 7'd0, 1'b1);
      send_msg({mrva_pkg::MSG_PROGRAM, 4'h3}, 7'd42, 7'd85, 1'b1);
      send_msg({mrva_pkg::MSG_NOTE_ON, mrva_pkg::CHAN_ZERO}, 7'd85, 7'd42, 1'b1);
      send_msg({mrva_pkg::MSG_NOTE_OFF, 4'h6}, 7'd0, 7'd85, 1'b1);
      send_msg({mrva_pkg::MSG_NOTE_OFF, mrva_pkg::CHAN_ZERO}, 7'd127, 7'd42, 1'b1);

      // random
      sent = 0;
      while (sent < RANDOM_MSGS) begin
         gaps_on = !(sent >= 60 && sent < 100);
         if (sent == 120 && board.event_q.size() != 0) begin
            req_ch.valid <= 1'b0;
            while (board.event_q.size() != 0) @(posedge clock);
         end
         kind = $urandom_range(0, 99);
         chan = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : mrva_pkg::CHAN_ZERO;
         if (kind < 35) begin
            send_msg({mrva_pkg::MSG_NOTE_ON, chan}, pick_note(),
                     7'($urandom_range(0, 127)), 1'b1);
         end else if (kind < 60) begin
            send_msg({mrva_pkg::MSG_NOTE_OFF, 4'($urandom_range(0, 15))}, pick_note(),
                     7'($urandom_range(0, 127)), 1'b1);
         end else if (kind < 70) begin
            send_msg({mrva_pkg::MSG_PROGRAM, 4'($urandom_range(0, 15))},
                     7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)), 1'b1);
         end else if (kind < 80) begin
            if ($urandom_range(0, 9) < 7) begin
               send_msg({mrva_pkg::MSG_CTRL, 4'($urandom_range(0, 15))}, mrva_pkg::CTRL_BANK,
                        ($urandom_range(0, 1) == 0) ? 7'($urandom_range(0, 3))
                                                    : 7'($urandom_range(0, 127)), 1'b1);
            end else begin
               send_msg({mrva_pkg::MSG_CTRL, 4'($urandom_range(0, 15))},
                        7'($urandom_range(1, 127)), 7'($urandom_range(0, 127)), 1'b1);
            end
         end else if (kind < 90) begin
            send_msg(8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                     7'($urandom_range(0, 127)), 1'b1);
         end else begin
            send_msg(8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                     7'($urandom_range(0, 127)), 1'b0);
         end
         if (kind < 90) sent++;
      end
      req_ch.valid <= 1'b0;
      gaps_on = 1'b1;

      drain = 0;
      while (board.event_q.size() != 0 && drain < 20000) begin
         @(posedge clock);
         drain++;
      end
      repeat (VOICES + 8) @(posedge clock);
      if (board.event_q.size() != 0) begin
         $error("%0d expected events never arrived", board.event_q.size());
         board.errors++;
      end

      if (board.errors == 0) begin
         $display("midi_round_robin_voice_allocator_tb: PASS");
      end else begin
         $display("midi_round_robin_voice_allocator_tb: FAIL");
      end
      $finish;
   end
endmodule

[files.f]
sv/mrva_pkg.sv
sv/mrva_chan_if.sv
sv/mrva_ram.sv
sv/midi_round_robin_voice_allocator.sv
bench/midi_round_robin_voice_allocator_tb.sv
